// ----- rtl/core/hsvg_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvg_pkg
// shared constants, register codes and item types of the hsv gradient row
// color block
// ----------------------------------------------------------------------------
package hsvg_pkg;

   // gradient height in rows
   localparam int unsigned Rows = 220;

   localparam int unsigned FracOne    = 1000;
   localparam int unsigned SectorSpan = 600;
   localparam int unsigned Full       = 255;

   localparam int unsigned RowW  = 8;
   localparam int unsigned HueW  = 12;
   localparam int unsigned SumW  = HueW + 1;
   localparam int unsigned FracW = 10;
   localparam int unsigned PartW = 10;
   localparam int unsigned ChanW = 8;
   localparam int unsigned PixW  = 16;

   // row compare against the height, wide enough for up to 1024 rows
   localparam logic [10:0] RowsCmp = 11'(Rows);

   // row * 1000 / Rows as a multiply by a rounded-up reciprocal
   localparam int unsigned     FracShift   = 20;
   localparam int unsigned     FracMulW    = 30;
   localparam longint unsigned FracMulWide =
      ((longint'(FracOne) << FracShift) + longint'(Rows) - 1) / longint'(Rows);
   localparam logic [FracMulW-1:0] FracMul = FracMulW'(FracMulWide);

   // x / 1000 for x below 2**22
   localparam int unsigned     ThouShift   = 32;
   localparam int unsigned     ThouMulW    = 23;
   localparam longint unsigned ThouMulWide =
      ((64'd1 << ThouShift) + longint'(FracOne) - 1) / longint'(FracOne);
   localparam logic [ThouMulW-1:0] ThouMul = ThouMulW'(ThouMulWide);

   // hue / 600 for a 13-bit hue
   localparam int unsigned     SecShift   = 23;
   localparam int unsigned     SecMulW    = 14;
   localparam longint unsigned SecMulWide =
      ((64'd1 << SecShift) + longint'(SectorSpan) - 1) / longint'(SectorSpan);
   localparam logic [SecMulW-1:0] SecMul = SecMulW'(SecMulWide);

   // x / 600 for x below 2**18
   localparam int unsigned     SpanShift   = 28;
   localparam int unsigned     SpanMulW    = 19;
   localparam longint unsigned SpanMulWide =
      ((64'd1 << SpanShift) + longint'(SectorSpan) - 1) / longint'(SectorSpan);
   localparam logic [SpanMulW-1:0] SpanMul = SpanMulW'(SpanMulWide);

   // x / 255 for x below 2**16
   localparam int unsigned     FullShift   = 24;
   localparam int unsigned     FullMulW    = 17;
   localparam longint unsigned FullMulWide =
      ((64'd1 << FullShift) + longint'(Full) - 1) / longint'(Full);
   localparam logic [FullMulW-1:0] FullMul = FullMulW'(FullMulWide);

   // color wheel sectors
   localparam logic [2:0] SectorRedYellow   = 3'd0;
   localparam logic [2:0] SectorYellowGreen = 3'd1;
   localparam logic [2:0] SectorGreenCyan   = 3'd2;
   localparam logic [2:0] SectorCyanBlue    = 3'd3;
   localparam logic [2:0] SectorBlueMagenta = 3'd4;
   localparam logic [2:0] SectorMagentaRed  = 3'd5;

   // register indexes
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CsrDataW  = 12;
   localparam logic [CsrIndexW-1:0] CsrHueStart   = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrHueEnd     = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrSaturation = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrBrightness = 2'd3;

   localparam logic [HueW-1:0]  HueStartReset   = 12'd0;
   localparam logic [HueW-1:0]  HueEndReset     = 12'd1800;
   localparam logic [ChanW-1:0] SaturationReset = 8'd255;
   localparam logic [ChanW-1:0] BrightnessReset = 8'd255;

   typedef struct packed {
      logic [HueW-1:0]  hue_start;
      logic [HueW-1:0]  hue_end;
      logic [ChanW-1:0] saturation;
      logic [ChanW-1:0] brightness;
   } cfg_type;

   typedef struct packed {
      logic [SumW-1:0] hue;
   } hue_item_type;

   typedef struct packed {
      logic [2:0]       sector;
      logic [PartW-1:0] part;
   } sect_item_type;

endpackage

// ----- rtl/core/hsvg_if.sv -----
// ----------------------------------------------------------------------------
// hsvg_if
// valid/ready channels of the hsv gradient row color block
// ----------------------------------------------------------------------------
interface hsvg_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsvg_pkg::RowW-1:0]   row_index;

   modport source (output valid, output row_index, input ready);
   modport sink   (input valid, input row_index, output ready);
endinterface

interface hsvg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsvg_pkg::ChanW-1:0]  red_level;
   logic [hsvg_pkg::ChanW-1:0]  green_level;
   logic [hsvg_pkg::ChanW-1:0]  blue_level;
   logic [hsvg_pkg::PixW-1:0]   packed_565;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, output packed_565, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, input packed_565, output ready);
endinterface

// ----- rtl/core/hsv_gradient_row_color_top.sv -----
// ----------------------------------------------------------------------------
// hsv_gradient_row_color_top
// row index to hsv gradient color, as 8-bit channels and packed rgb565
//
// req_chan carries one row index per item; rsp_chan returns one color item
// for every request item, in order. The hue moves from hue_start at row 0
// toward hue_end at the last row; saturation and brightness apply to all.
// Registers are written through csr_write_en / csr_index / csr_write_data,
// one register per cycle; the user must write them only while no item is
// in flight, which the block itself does not enforce. The pipeline has five
// stages of hue interpolation, two of sector split and five of color
// conversion. Throughput is one item per clock while the output is not
// held; every stage has its own valid bit, so bubbles are squeezed out
// and new items are taken while a finished one waits at the output.
// When rsp_chan.ready is low the pipeline fills up and then req_chan.ready
// drops; nothing is lost or repeated. Synchronous reset empties the
// pipeline and sets hue 0 to 1800, saturation 255, brightness 255.
// ----------------------------------------------------------------------------
module hsv_gradient_row_color_top (
   input  logic                                 clock,
   input  logic                                 reset,
   hsvg_req_if.sink                             req_chan,
   hsvg_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [hsvg_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [hsvg_pkg::CsrDataW-1:0]        csr_write_data
);

   logic [hsvg_pkg::HueW-1:0]  hue_start_ff;
   logic [hsvg_pkg::HueW-1:0]  hue_end_ff;
   logic [hsvg_pkg::ChanW-1:0] saturation_ff;
   logic [hsvg_pkg::ChanW-1:0] brightness_ff;

   hsvg_pkg::cfg_type          cfg;
   hsvg_pkg::hue_item_type     hue_item;
   hsvg_pkg::sect_item_type    sect_item;
   logic                       hue_valid, hue_ready;
   logic                       sect_valid, sect_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_start_ff  <= hsvg_pkg::HueStartReset;
         hue_end_ff    <= hsvg_pkg::HueEndReset;
         saturation_ff <= hsvg_pkg::SaturationReset;
         brightness_ff <= hsvg_pkg::BrightnessReset;
      end else if (csr_write_en) begin
         case (csr_index)
            hsvg_pkg::CsrHueStart:   hue_start_ff  <= csr_write_data;
            hsvg_pkg::CsrHueEnd:     hue_end_ff    <= csr_write_data;
            hsvg_pkg::CsrSaturation: saturation_ff <= csr_write_data[hsvg_pkg::ChanW-1:0];
            hsvg_pkg::CsrBrightness: brightness_ff <= csr_write_data[hsvg_pkg::ChanW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.hue_start  = hue_start_ff;
      cfg.hue_end    = hue_end_ff;
      cfg.saturation = saturation_ff;
      cfg.brightness = brightness_ff;
   end

   hsvg_hue_interp u_hue_interp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .up_valid  (req_chan.valid),
      .up_ready  (req_chan.ready),
      .row_index (req_chan.row_index),
      .dn_valid  (hue_valid),
      .dn_ready  (hue_ready),
      .dn_item   (hue_item)
   );

   hsvg_sector u_sector (
      .clock    (clock),
      .reset    (reset),
      .up_valid (hue_valid),
      .up_ready (hue_ready),
      .up_item  (hue_item),
      .dn_valid (sect_valid),
      .dn_ready (sect_ready),
      .dn_item  (sect_item)
   );

   hsvg_rgb u_rgb (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .up_valid    (sect_valid),
      .up_ready    (sect_ready),
      .up_item     (sect_item),
      .dn_valid    (rsp_chan.valid),
      .dn_ready    (rsp_chan.ready),
      .red_level   (rsp_chan.red_level),
      .green_level (rsp_chan.green_level),
      .blue_level  (rsp_chan.blue_level),
      .packed_565  (rsp_chan.packed_565)
   );

   empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && req_chan.ready))
      else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/hsvg_hue_interp.sv -----
// ----------------------------------------------------------------------------
// hsvg_hue_interp
// five-stage pipeline from row index to interpolated hue
// ----------------------------------------------------------------------------
module hsvg_hue_interp (
   input  logic                        clock,
   input  logic                        reset,
   input  hsvg_pkg::cfg_type           cfg,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic [hsvg_pkg::RowW-1:0]   row_index,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output hsvg_pkg::hue_item_type      dn_item
);

   logic [4:0] v_ff;
   logic [4:0] adv;

   logic                                         row_ge_ff;
   logic [hsvg_pkg::RowW+hsvg_pkg::FracMulW-1:0] fprod_ff;
   logic [hsvg_pkg::FracW-1:0]                   frac_ff;
   logic                                         down2_ff;
   logic [hsvg_pkg::HueW-1:0]                    start2_ff;
   logic [hsvg_pkg::HueW+hsvg_pkg::FracW-1:0]    mprod_ff;
   logic                                         down3_ff;
   logic [hsvg_pkg::HueW-1:0]                    start3_ff;
   logic [hsvg_pkg::HueW+hsvg_pkg::FracW+hsvg_pkg::ThouMulW-1:0] qprod_ff;
   logic [hsvg_pkg::SumW-1:0]                    hue_ff;

   logic                       down_in;
   logic [hsvg_pkg::HueW-1:0]  diff_in;
   logic [hsvg_pkg::HueW-1:0]  mag_in;
   logic [hsvg_pkg::SumW-1:0]  hue_in;

   always_comb begin
      adv[4] = !v_ff[4] || dn_ready;
      adv[3] = !v_ff[3] || adv[4];
      adv[2] = !v_ff[2] || adv[3];
      adv[1] = !v_ff[1] || adv[2];
      adv[0] = !v_ff[0] || adv[1];
   end

   assign up_ready = adv[0];
   assign dn_valid = v_ff[4];
   assign dn_item.hue = hue_ff;

   always_comb begin
      down_in = cfg.hue_end < cfg.hue_start;
      diff_in = down_in ? (cfg.hue_start - cfg.hue_end) : (cfg.hue_end - cfg.hue_start);
      mag_in  = qprod_ff[hsvg_pkg::ThouShift +: hsvg_pkg::HueW];
      if (down3_ff) begin
         hue_in = {1'b0, start3_ff} - {1'b0, mag_in};
      end else begin
         hue_in = {1'b0, start3_ff} + {1'b0, mag_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= up_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
         if (adv[4]) v_ff[4] <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         row_ge_ff <= {3'b000, row_index} >= hsvg_pkg::RowsCmp;
         fprod_ff  <= row_index * hsvg_pkg::FracMul;
      end
      if (adv[1]) begin
         frac_ff <= row_ge_ff ? hsvg_pkg::FracW'(hsvg_pkg::FracOne)
                              : fprod_ff[hsvg_pkg::FracShift +: hsvg_pkg::FracW];
      end
      if (adv[2]) begin
         down2_ff  <= down_in;
         start2_ff <= cfg.hue_start;
         mprod_ff  <= diff_in * frac_ff;
      end
      if (adv[3]) begin
         down3_ff  <= down2_ff;
         start3_ff <= start2_ff;
         qprod_ff  <= mprod_ff * hsvg_pkg::ThouMul;
      end
      if (adv[4]) begin
         hue_ff <= hue_in;
      end
   end

   frac_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> (frac_ff <= hsvg_pkg::FracW'(hsvg_pkg::FracOne)))
      else $error("row fraction above one");

endmodule

// ----- rtl/core/hsvg_sector.sv -----
// ----------------------------------------------------------------------------
// hsvg_sector
// two-stage split of a hue into wheel sector and position within the sector
// ----------------------------------------------------------------------------
module hsvg_sector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  hsvg_pkg::hue_item_type      up_item,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output hsvg_pkg::sect_item_type     dn_item
);

   logic [1:0] v_ff;
   logic [1:0] adv;

   logic [hsvg_pkg::SumW-1:0]                   hue_ff;
   logic [hsvg_pkg::SumW+hsvg_pkg::SecMulW-1:0] hprod_ff;
   logic [2:0]                                  sector_ff;
   logic [hsvg_pkg::PartW-1:0]                  part_ff;

   logic [3:0]                 quot_in;
   logic [hsvg_pkg::SumW-1:0]  base_in;
   logic [hsvg_pkg::SumW-1:0]  rem_in;
   logic [2:0]                 sector_in;

   always_comb begin
      adv[1] = !v_ff[1] || dn_ready;
      adv[0] = !v_ff[0] || adv[1];
   end

   assign up_ready = adv[0];
   assign dn_valid = v_ff[1];
   assign dn_item.sector = sector_ff;
   assign dn_item.part   = part_ff;

   always_comb begin
      quot_in = hprod_ff[hsvg_pkg::SecShift +: 4];
      base_in = hsvg_pkg::SumW'(quot_in * hsvg_pkg::SectorSpan);
      rem_in  = hue_ff - base_in;
      // wheel wraps every six sectors
      if (quot_in >= 4'd12) begin
         sector_in = 3'(quot_in - 4'd12);
      end else if (quot_in >= 4'd6) begin
         sector_in = 3'(quot_in - 4'd6);
      end else begin
         sector_in = quot_in[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= up_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         hue_ff   <= up_item.hue;
         hprod_ff <= up_item.hue * hsvg_pkg::SecMul;
      end
      if (adv[1]) begin
         sector_ff <= sector_in;
         part_ff   <= rem_in[hsvg_pkg::PartW-1:0];
      end
   end

   part_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> (part_ff < hsvg_pkg::PartW'(hsvg_pkg::SectorSpan)))
      else $error("sector position out of range");

   sector_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> (sector_ff <= hsvg_pkg::SectorMagentaRed))
      else $error("sector code out of range");

endmodule

// ----- rtl/core/hsvg_rgb.sv -----
// ----------------------------------------------------------------------------
// hsvg_rgb
// five-stage conversion of sector, position, saturation and brightness
// to 8-bit channels and the packed 565 color
// ----------------------------------------------------------------------------
module hsvg_rgb (
   input  logic                        clock,
   input  logic                        reset,
   input  hsvg_pkg::cfg_type           cfg,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  hsvg_pkg::sect_item_type     up_item,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output logic [hsvg_pkg::ChanW-1:0]  red_level,
   output logic [hsvg_pkg::ChanW-1:0]  green_level,
   output logic [hsvg_pkg::ChanW-1:0]  blue_level,
   output logic [hsvg_pkg::PixW-1:0]   packed_565
);

   localparam int unsigned ProdW = 18;
   localparam int unsigned NumW  = 16;

   logic [4:0] v_ff;
   logic [4:0] adv;

   logic [2:0]                 sec0_ff, sec1_ff, sec2_ff, sec3_ff;
   logic [hsvg_pkg::ChanW-1:0] val0_ff, val1_ff, val2_ff, val3_ff;
   logic [ProdW-1:0]           sp_ff, sq_ff;
   logic [NumW-1:0]            lon_ff;
   logic [ProdW+hsvg_pkg::SpanMulW-1:0] aprod_ff, bprod_ff;
   logic [NumW+hsvg_pkg::FullMulW-1:0]  loprod_ff;
   logic [NumW-1:0]            dnn_ff, upn_ff;
   logic [hsvg_pkg::ChanW-1:0] lo2_ff, lo3_ff;
   logic [NumW+hsvg_pkg::FullMulW-1:0]  dnprod_ff, upprod_ff;
   logic [hsvg_pkg::ChanW-1:0] red_ff, green_ff, blue_ff;
   logic [hsvg_pkg::PixW-1:0]  packed_ff;

   logic [hsvg_pkg::PartW-1:0] rest_in;
   logic [hsvg_pkg::ChanW-1:0] a_in, b_in, dn_in, up_in;
   logic [hsvg_pkg::ChanW-1:0] red_in, green_in, blue_in;

   always_comb begin
      adv[4] = !v_ff[4] || dn_ready;
      adv[3] = !v_ff[3] || adv[4];
      adv[2] = !v_ff[2] || adv[3];
      adv[1] = !v_ff[1] || adv[2];
      adv[0] = !v_ff[0] || adv[1];
   end

   assign up_ready    = adv[0];
   assign dn_valid    = v_ff[4];
   assign red_level   = red_ff;
   assign green_level = green_ff;
   assign blue_level  = blue_ff;
   assign packed_565  = packed_ff;

   always_comb begin
      rest_in = hsvg_pkg::PartW'(hsvg_pkg::SectorSpan) - up_item.part;
      a_in    = aprod_ff[hsvg_pkg::SpanShift +: hsvg_pkg::ChanW];
      b_in    = bprod_ff[hsvg_pkg::SpanShift +: hsvg_pkg::ChanW];
      dn_in   = dnprod_ff[hsvg_pkg::FullShift +: hsvg_pkg::ChanW];
      up_in   = upprod_ff[hsvg_pkg::FullShift +: hsvg_pkg::ChanW];
      case (sec3_ff)
         hsvg_pkg::SectorRedYellow: begin
            red_in = val3_ff; green_in = up_in;   blue_in = lo3_ff;
         end
         hsvg_pkg::SectorYellowGreen: begin
            red_in = dn_in;   green_in = val3_ff; blue_in = lo3_ff;
         end
         hsvg_pkg::SectorGreenCyan: begin
            red_in = lo3_ff;  green_in = val3_ff; blue_in = up_in;
         end
         hsvg_pkg::SectorCyanBlue: begin
            red_in = lo3_ff;  green_in = dn_in;   blue_in = val3_ff;
         end
         hsvg_pkg::SectorBlueMagenta: begin
            red_in = up_in;   green_in = lo3_ff;  blue_in = val3_ff;
         end
         default: begin
            red_in = val3_ff; green_in = lo3_ff;  blue_in = dn_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= up_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
         if (adv[4]) v_ff[4] <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec0_ff <= up_item.sector;
         val0_ff <= cfg.brightness;
         sp_ff   <= cfg.saturation * up_item.part;
         sq_ff   <= cfg.saturation * rest_in;
         lon_ff  <= cfg.brightness * (hsvg_pkg::ChanW'(hsvg_pkg::Full) - cfg.saturation);
      end
      if (adv[1]) begin
         sec1_ff   <= sec0_ff;
         val1_ff   <= val0_ff;
         aprod_ff  <= sp_ff * hsvg_pkg::SpanMul;
         bprod_ff  <= sq_ff * hsvg_pkg::SpanMul;
         loprod_ff <= lon_ff * hsvg_pkg::FullMul;
      end
      if (adv[2]) begin
         sec2_ff <= sec1_ff;
         val2_ff <= val1_ff;
         lo2_ff  <= loprod_ff[hsvg_pkg::FullShift +: hsvg_pkg::ChanW];
         dnn_ff  <= val1_ff * (hsvg_pkg::ChanW'(hsvg_pkg::Full) - a_in);
         upn_ff  <= val1_ff * (hsvg_pkg::ChanW'(hsvg_pkg::Full) - b_in);
      end
      if (adv[3]) begin
         sec3_ff   <= sec2_ff;
         val3_ff   <= val2_ff;
         lo3_ff    <= lo2_ff;
         dnprod_ff <= dnn_ff * hsvg_pkg::FullMul;
         upprod_ff <= upn_ff * hsvg_pkg::FullMul;
      end
      if (adv[4]) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         packed_ff <= {red_in[7:3], green_in[7:2], blue_in[7:3]};
      end
   end

   low_below_ramps: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> ((lo3_ff <= dn_in) && (lo3_ff <= up_in) && (dn_in <= val3_ff)))
      else $error("channel ordering broken");

endmodule
